// ----- rtl/bil_pkg.sv -----
// Shared types and constants for the battery indicator LED PWM unit.
// No dependencies; the top level, the checker and the testbench use it.

package bil_pkg;

	localparam int SAMPLE_W = 12;
	localparam int LVL_W    = 11;
	localparam int COLOR_W  = 16;
	localparam int BRIGHT_W = 8;
	localparam int CH_W     = 6;	// widest RGB565 channel (green)
	localparam int MQ_W     = 16;	// peak on-time factor, Q0.16
	localparam int BQ_W     = 17;	// brightness factor, Q0.16 up to 1.0
	localparam int Q_W      = 17;	// scaled channel value before the channel divide
	localparam int CFG_W    = 16;

	localparam logic [LVL_W-1:0]    PWM_TOP      = 11'd2047;
	localparam logic [LVL_W-1:0]    ON_FLOOR     = 11'd180;
	localparam logic [MQ_W-1:0]     MAX_ON_Q     = 16'd52429;
	localparam logic [BQ_W-1:0]     MIN_BRIGHT_Q = 17'd3277;
	localparam logic [BQ_W-1:0]     FULL_BRIGHT_Q = 17'd65536;
	localparam logic [BRIGHT_W-1:0] BRIGHT_FLOOR = 8'd13;
	localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 8'd255;
	localparam logic [SAMPLE_W-1:0] SAMPLE_FULL  = 12'd4095;
	localparam logic [COLOR_W-1:0]  CYAN565      = 16'h07FF;
	localparam logic [CH_W-1:0]     CMAX5        = 6'd31;
	localparam logic [CH_W-1:0]     CMAX6        = 6'd63;

	// Register reset values.
	localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 8'd255;
	localparam logic [COLOR_W-1:0]  RST_COLOR      = 16'h07E0;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BRIGHTNESS   = 2'd0;
	localparam reg_idx_t REG_OVERRIDE_EN  = 2'd1;
	localparam reg_idx_t REG_OVERRIDE_CLR = 2'd2;
	localparam reg_idx_t REG_INDICATOR_ON = 2'd3;

	typedef logic [1:0] chan_idx_t;
	localparam chan_idx_t CH_RED   = 2'd0;
	localparam chan_idx_t CH_GREEN = 2'd1;
	localparam chan_idx_t CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] battery_sample;
		logic                charging;
	} in_item_t;

	typedef struct packed {
		logic [LVL_W-1:0] red_offtime;
		logic [LVL_W-1:0] green_offtime;
		logic [LVL_W-1:0] blue_offtime;
		logic             updated;
	} out_item_t;

endpackage

// ----- rtl/bil_stream_if.sv -----
// Valid/ready stream channel carrying one payload word per handshake.
// The payload type is set per instance, normally a struct from bil_pkg.

interface bil_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/battery_indicator_led_pwm_unit.sv -----
// Battery indicator LED PWM unit: one result word of RGB off-times per tick word.
// Depends on bil_pkg and bil_stream_if.
//
//   Channel     Dir  Payload                                              Handshake
//   sample_in   in   battery_sample[11:0], charging                       valid/ready
//   level_out   out  red/green/blue_offtime[10:0], updated                valid/ready
//   cfg port    in   cfg_wr_en, cfg_index[1:0], cfg_wdata[15:0]           write enable only
//
// A tick without an update goes straight to the output stage. An update tick runs a
// bit-serial sequencer: all-off override goes straight there too; override color or
// charging runs the peak multiply, then a multiply and divide per channel; the battery
// blend divides for red and green first. The divider gives one quotient bit per cycle.
// Reset clears the ring, the tick prescaler and the held levels (all LEDs off).
// A new word is taken while the previous result still waits at the output register.

module battery_indicator_led_pwm_unit #(
	parameter int AVERAGE_DEPTH    = 3,
	parameter int TICKS_PER_UPDATE = 25
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  bil_pkg::reg_idx_t         cfg_index,
	input  logic [bil_pkg::CFG_W-1:0] cfg_wdata,
	bil_stream_if.sink                sample_in,
	bil_stream_if.source              level_out
);

	localparam int DEN         = AVERAGE_DEPTH * 4095;
	localparam int SUM_W       = $clog2(DEN + 1);
	localparam int REM_W       = SUM_W + 1;
	localparam int NUM_BLEND_W = $clog2(63 * DEN + 1);
	localparam int NUM_W       = (NUM_BLEND_W > bil_pkg::Q_W) ? NUM_BLEND_W : bil_pkg::Q_W;
	localparam int CNT_W       = $clog2(NUM_W);
	localparam int ACC_W       = bil_pkg::BQ_W + bil_pkg::MQ_W;
	localparam int SCL_W       = ACC_W + 1;
	localparam int POS_W       = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int TK_W        = $clog2(TICKS_PER_UPDATE + 1);
	localparam int MQ_STEPS    = bil_pkg::MQ_W;
	localparam int CH_STEPS    = bil_pkg::CH_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_LD,
		S_RED_DIV,
		S_GRN_LD,
		S_GRN_DIV,
		S_MQ_LD,
		S_MQ_MUL,
		S_CH_LD,
		S_CH_MUL,
		S_CH_DIV,
		S_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [bil_pkg::BRIGHT_W-1:0] brightness_q;
	logic                         override_en_q;
	logic [bil_pkg::COLOR_W-1:0]  override_color_q;
	logic                         indicator_on_q;

	// Battery averaging state.
	logic [bil_pkg::SAMPLE_W-1:0] ring_q [AVERAGE_DEPTH];
	logic [POS_W-1:0]             pos_q;
	logic [SUM_W-1:0]             sum_q;
	logic [TK_W-1:0]              tick_q;

	// Channel values and held levels.
	logic [4:0]                   red_q;
	logic [5:0]                   grn_q;
	logic [4:0]                   blu_q;
	logic [bil_pkg::LVL_W-1:0]    held_q [3];
	logic                         upd_q;
	bil_pkg::chan_idx_t           chan_idx_q;
	logic [bil_pkg::MQ_W-1:0]     maxq_q;

	// Serial multiplier and divider.
	logic [ACC_W-1:0]             acc_q;
	logic [bil_pkg::BQ_W-1:0]     mcand_q;
	logic [bil_pkg::MQ_W-1:0]     mplr_q;
	logic [NUM_W-1:0]             num_q;
	logic [REM_W-1:0]             rem_q;
	logic [NUM_W-1:0]             quo_q;
	logic [CNT_W-1:0]             cnt_q;

	// Output register.
	logic                         out_valid_q;
	bil_pkg::out_item_t           out_q;

	logic                         accept;
	logic                         out_free;
	logic [bil_pkg::BQ_W-1:0]     bq;
	logic [bil_pkg::CH_W-1:0]     chan_c;
	logic [REM_W-1:0]             div_d;
	logic [REM_W-1:0]             rem_sh;
	logic                         div_ge;
	logic [REM_W-1:0]             rem_nx;
	logic [NUM_W-1:0]             quo_nx;
	logic [ACC_W-1:0]             acc_nx;
	logic [SCL_W-1:0]             scaled;
	logic [NUM_W-1:0]             on_f;
	logic [NUM_W-1:0]             on_c;
	logic [bil_pkg::LVL_W-1:0]    level;
	logic [bil_pkg::SAMPLE_W-1:0] depletion;
	logic [SUM_W-1:0]             diff;

	assign accept    = sample_in.valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || level_out.ready;
	assign depletion = bil_pkg::SAMPLE_FULL - sample_in.data.battery_sample;
	assign diff      = SUM_W'(DEN) - sum_q;

	assign sample_in.ready = (state_q == S_IDLE);
	assign level_out.valid = out_valid_q;
	assign level_out.data  = out_q;

	// Brightness factor: b*65536/255 is b*257 below full scale, exactly 1.0 at full, MIN_BRIGHT_Q below BRIGHT_FLOOR.
	always_comb begin
		if (brightness_q < bil_pkg::BRIGHT_FLOOR) begin
			bq = bil_pkg::MIN_BRIGHT_Q;
		end else if (brightness_q == bil_pkg::BRIGHT_FULL) begin
			bq = bil_pkg::FULL_BRIGHT_Q;
		end else begin
			bq = {1'b0, brightness_q, brightness_q};
		end
	end

	always_comb begin
		case (chan_idx_q)
			bil_pkg::CH_RED:   chan_c = {1'b0, red_q};
			bil_pkg::CH_GREEN: chan_c = grn_q;
			default:           chan_c = {1'b0, blu_q};
		endcase
	end

	always_comb begin
		if (state_q == S_CH_DIV) begin
			div_d = (chan_idx_q == bil_pkg::CH_GREEN) ? REM_W'(bil_pkg::CMAX6)
			                                          : REM_W'(bil_pkg::CMAX5);
		end else begin
			div_d = REM_W'(DEN);
		end
	end

	// One restoring-division step: bring in the next numerator bit, subtract if it fits.
	assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign div_ge = (rem_sh >= div_d);
	assign rem_nx = div_ge ? (rem_sh - div_d) : rem_sh;
	assign quo_nx = {quo_q[NUM_W-2:0], div_ge};

	// One shift-add multiply step, multiplier taken MSB first.
	assign acc_nx = (acc_q << 1) + (mplr_q[bil_pkg::MQ_W-1] ? ACC_W'(mcand_q) : '0);

	// Times PWM_TOP (2^11 - 1), then drop the Q0.16 fraction.
	assign scaled = (SCL_W'(acc_nx) << bil_pkg::LVL_W) - SCL_W'(acc_nx);

	always_comb begin
		if ((chan_c != '0) && (quo_nx < NUM_W'(bil_pkg::ON_FLOOR))) begin
			on_f = NUM_W'(bil_pkg::ON_FLOOR);
		end else begin
			on_f = quo_nx;
		end
		if (on_f > NUM_W'(bil_pkg::PWM_TOP)) begin
			on_c = NUM_W'(bil_pkg::PWM_TOP);
		end else begin
			on_c = on_f;
		end
		level = bil_pkg::LVL_W'(NUM_W'(bil_pkg::PWM_TOP) - on_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			brightness_q     <= bil_pkg::RST_BRIGHTNESS;
			override_en_q    <= 1'b0;
			override_color_q <= bil_pkg::RST_COLOR;
			indicator_on_q   <= 1'b1;
			for (int i = 0; i < AVERAGE_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			pos_q       <= '0;
			sum_q       <= '0;
			tick_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				held_q[i] <= bil_pkg::PWM_TOP;
			end
			upd_q       <= 1'b0;
			chan_idx_q  <= bil_pkg::CH_RED;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					bil_pkg::REG_BRIGHTNESS:   brightness_q <= cfg_wdata[bil_pkg::BRIGHT_W-1:0];
					bil_pkg::REG_OVERRIDE_EN:  override_en_q <= cfg_wdata[0];
					bil_pkg::REG_OVERRIDE_CLR: override_color_q <= cfg_wdata;
					bil_pkg::REG_INDICATOR_ON: indicator_on_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			// In S_FINISH the output register is reloaded below instead.
			if (out_valid_q && level_out.ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (tick_q >= TK_W'(TICKS_PER_UPDATE)) begin
							tick_q <= TK_W'(1);
							upd_q  <= 1'b1;
							if (override_en_q) begin
								if (indicator_on_q) begin
									red_q   <= override_color_q[15:11];
									grn_q   <= override_color_q[10:5];
									blu_q   <= override_color_q[4:0];
									state_q <= S_MQ_LD;
								end else begin
									for (int i = 0; i < 3; i++) begin
										held_q[i] <= bil_pkg::PWM_TOP;
									end
									state_q <= S_FINISH;
								end
							end else if (sample_in.data.charging) begin
								red_q   <= bil_pkg::CYAN565[15:11];
								grn_q   <= bil_pkg::CYAN565[10:5];
								blu_q   <= bil_pkg::CYAN565[4:0];
								state_q <= S_MQ_LD;
							end else begin
								// Keep a running sum so the average needs no pass over the ring.
								ring_q[pos_q] <= depletion;
								sum_q <= sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(depletion);
								pos_q <= (pos_q == POS_W'(AVERAGE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
								state_q <= S_RED_LD;
							end
						end else begin
							tick_q  <= tick_q + 1'b1;
							upd_q   <= 1'b0;
							state_q <= S_FINISH;
						end
					end
				end

				S_RED_LD: begin
					num_q   <= (NUM_W'(sum_q) << 5) - NUM_W'(sum_q);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_RED_DIV;
				end

				S_RED_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						red_q   <= quo_nx[4:0];
						state_q <= S_GRN_LD;
					end
				end

				S_GRN_LD: begin
					num_q   <= (NUM_W'(diff) << 6) - NUM_W'(diff);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_GRN_DIV;
				end

				S_GRN_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						grn_q   <= quo_nx[5:0];
						blu_q   <= '0;
						state_q <= S_MQ_LD;
					end
				end

				S_MQ_LD: begin
					acc_q   <= '0;
					mcand_q <= bq;
					mplr_q  <= bil_pkg::MAX_ON_Q;
					cnt_q   <= '0;
					state_q <= S_MQ_MUL;
				end

				S_MQ_MUL: begin
					acc_q  <= acc_nx;
					mplr_q <= mplr_q << 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MQ_STEPS - 1)) begin
						maxq_q     <= acc_nx[bil_pkg::MQ_W +: bil_pkg::MQ_W];
						chan_idx_q <= bil_pkg::CH_RED;
						state_q    <= S_CH_LD;
					end
				end

				S_CH_LD: begin
					acc_q   <= '0;
					mcand_q <= bil_pkg::BQ_W'(maxq_q);
					mplr_q  <= {chan_c, (bil_pkg::MQ_W - bil_pkg::CH_W)'(0)};
					cnt_q   <= '0;
					state_q <= S_CH_MUL;
				end

				S_CH_MUL: begin
					acc_q  <= acc_nx;
					mplr_q <= mplr_q << 1;
					if (cnt_q == CNT_W'(CH_STEPS - 1)) begin
						num_q   <= NUM_W'(scaled[SCL_W-1:16]);
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_CH_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				S_CH_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						held_q[chan_idx_q] <= level;
						if (chan_idx_q == bil_pkg::CH_BLUE) begin
							state_q <= S_FINISH;
						end else begin
							chan_idx_q <= chan_idx_q + 1'b1;
							state_q    <= S_CH_LD;
						end
					end
				end

				S_FINISH: begin
					if (out_free) begin
						out_q.red_offtime   <= held_q[0];
						out_q.green_offtime <= held_q[1];
						out_q.blue_offtime  <= held_q[2];
						out_q.updated       <= upd_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- tb/battery_indicator_led_pwm_unit_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the battery indicator LED PWM unit: watches the register port and both
// stream channels, predicts every level word and compares it field by field.
// Depends on bil_pkg.

module battery_indicator_led_pwm_unit_checker
	import bil_pkg::*;
#(
	parameter int AVERAGE_DEPTH    = 3,
	parameter int TICKS_PER_UPDATE = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             sample_valid,
	input  logic             sample_ready,
	input  in_item_t         sample_word,
	input  logic             level_valid,
	input  logic             level_ready,
	input  out_item_t        level_word,
	output int               mismatches,
	output int               levels_owed
);

	logic [BRIGHT_W-1:0] brightness;
	logic                override_en;
	logic [COLOR_W-1:0]  override_color;
	logic                indicator_on;

	logic [SAMPLE_W-1:0] depletion [AVERAGE_DEPTH];
	int                  ring_pos;
	int                  ticks_since;
	logic [LVL_W-1:0]    held [3];
	out_item_t           expected_levels [$];

	function automatic logic [LVL_W-1:0] offtime(input int unsigned chan,
		input int unsigned chan_max);
		longint unsigned bright_q, peak_q, on_time, chan_l, max_l;
		chan_l = chan;
		max_l = chan_max;
		if (brightness >= BRIGHT_FLOOR) begin
			bright_q = brightness;
			bright_q = (bright_q * 65536) / 255;
		end else begin
			bright_q = MIN_BRIGHT_Q;
		end
		peak_q = (bright_q * MAX_ON_Q) >> 16;
		on_time = (chan_l * peak_q * PWM_TOP) / (max_l * 65536);
		// A lit channel never drops below the visible floor.
		if (chan != 0 && on_time < ON_FLOOR)
			on_time = ON_FLOOR;
		if (on_time > PWM_TOP)
			on_time = PWM_TOP;
		return LVL_W'(PWM_TOP - on_time);
	endfunction

	function automatic void show_rgb(input int unsigned r5, input int unsigned g6,
		input int unsigned b5);
		held[CH_RED]   = offtime(r5, CMAX5);
		held[CH_GREEN] = offtime(g6, CMAX6);
		held[CH_BLUE]  = offtime(b5, CMAX5);
	endfunction

	function automatic void show_565(input logic [COLOR_W-1:0] color);
		show_rgb(color[15:11], color[10:5], color[4:0]);
	endfunction

	function automatic void refresh_levels(input in_item_t w);
		int unsigned total, den;
		if (override_en) begin
			if (indicator_on) begin
				show_565(override_color);
			end else begin
				held[CH_RED]   = PWM_TOP;
				held[CH_GREEN] = PWM_TOP;
				held[CH_BLUE]  = PWM_TOP;
			end
		end else if (w.charging) begin
			show_565(CYAN565);
		end else begin
			depletion[ring_pos] = SAMPLE_FULL - w.battery_sample;
			ring_pos = (ring_pos == AVERAGE_DEPTH - 1) ? 0 : ring_pos + 1;
			total = 0;
			for (int i = 0; i < AVERAGE_DEPTH; i++)
				total += depletion[i];
			den = AVERAGE_DEPTH * SAMPLE_FULL;
			if (total > den)
				total = den;
			show_rgb((CMAX5 * total) / den, (CMAX6 * (den - total)) / den, 0);
		end
	endfunction

	function automatic out_item_t next_levels(input in_item_t w);
		out_item_t lv;
		lv.updated = 1'b0;
		if (ticks_since >= TICKS_PER_UPDATE) begin
			refresh_levels(w);
			ticks_since = 0;
			lv.updated = 1'b1;
		end
		ticks_since++;
		lv.red_offtime   = held[CH_RED];
		lv.green_offtime = held[CH_GREEN];
		lv.blue_offtime  = held[CH_BLUE];
		return lv;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			brightness = RST_BRIGHTNESS;
			override_en = 1'b0;
			override_color = RST_COLOR;
			indicator_on = 1'b1;
			for (int i = 0; i < AVERAGE_DEPTH; i++)
				depletion[i] = '0;
			ring_pos = 0;
			ticks_since = 0;
			held[CH_RED]   = PWM_TOP;
			held[CH_GREEN] = PWM_TOP;
			held[CH_BLUE]  = PWM_TOP;
			expected_levels.delete();
			mismatches = 0;
			levels_owed <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
				REG_BRIGHTNESS:   brightness = cfg_wdata[BRIGHT_W-1:0];
				REG_OVERRIDE_EN:  override_en = cfg_wdata[0];
				REG_OVERRIDE_CLR: override_color = cfg_wdata[COLOR_W-1:0];
				REG_INDICATOR_ON: indicator_on = cfg_wdata[0];
				endcase
			end
			if (level_valid && level_ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t ns: level word with none expected, got %0d %0d %0d %0d",
						$time, level_word.red_offtime, level_word.green_offtime,
						level_word.blue_offtime, level_word.updated);
					mismatches++;
				end else begin
					want = expected_levels.pop_front();
					check_field("red_offtime", want.red_offtime, level_word.red_offtime);
					check_field("green_offtime", want.green_offtime,
						level_word.green_offtime);
					check_field("blue_offtime", want.blue_offtime, level_word.blue_offtime);
					check_field("updated", want.updated, level_word.updated);
				end
			end
			if (sample_valid && sample_ready)
				expected_levels.push_back(next_levels(sample_word));
			levels_owed <= expected_levels.size();
		end
	end

endmodule

// ----- tb/battery_indicator_led_pwm_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the battery indicator LED PWM unit testbench: clock, reset, register writes,
// tick words with bursty pacing and a stalling receiver. Depends on bil_pkg,
// bil_stream_if, the unit and battery_indicator_led_pwm_unit_checker.

module battery_indicator_led_pwm_unit_tb;
	import bil_pkg::*;

	localparam int AVERAGE_DEPTH    = 3;
	localparam int TICKS_PER_UPDATE = 25;
	localparam int RANDOM_UPDATES   = 2;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	reg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int               mismatches;
	int               levels_owed;

	int ticks_left;		// ticks up to and including the next update tick
	int burst_left;
	bit gaps_on;
	int updates_sent;
	int dim_steps [5] = '{0, 12, 13, 254, 255};

	bil_stream_if #(.payload_t(in_item_t))  sample_ch ();
	bil_stream_if #(.payload_t(out_item_t)) level_ch ();

	battery_indicator_led_pwm_unit #(
		.AVERAGE_DEPTH(AVERAGE_DEPTH),
		.TICKS_PER_UPDATE(TICKS_PER_UPDATE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample_in(sample_ch),
		.level_out(level_ch)
	);

	battery_indicator_led_pwm_unit_checker #(
		.AVERAGE_DEPTH(AVERAGE_DEPTH),
		.TICKS_PER_UPDATE(TICKS_PER_UPDATE)
	) level_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample_valid(sample_ch.valid),
		.sample_ready(sample_ch.ready),
		.sample_word(sample_ch.data),
		.level_valid(level_ch.valid),
		.level_ready(level_ch.ready),
		.level_word(level_ch.data),
		.mismatches(mismatches),
		.levels_owed(levels_owed)
	);

	always #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("[battery_indicator_led_pwm_unit] ERROR");
		$finish;
	end

	// The receiver switches at random between stall patterns.
	initial begin
		stall_mode_t mode;
		int hold, period, phase_cnt;
		level_ch.ready = 1'b0;
		mode = STALL_NONE;
		hold = 0;
		period = 2;
		phase_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				hold = $urandom_range(50, 300);
				period = $urandom_range(2, 6);
			end
			hold--;
			phase_cnt++;
			case (mode)
			STALL_NONE:     level_ch.ready <= 1'b1;
			STALL_RANDOM:   level_ch.ready <= ($urandom_range(0, 2) != 0);
			STALL_PERIODIC: level_ch.ready <= (phase_cnt % period == 0);
			default:        level_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic send_word(input logic [SAMPLE_W-1:0] level, input logic chg);
		sample_ch.valid <= 1'b1;
		sample_ch.data <= '{battery_sample: level, charging: chg};
		do @(posedge clk); while (!sample_ch.ready);
		ticks_left--;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				sample_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Filler ticks carry random words; only the update tick's word reaches the levels.
	task automatic send_update(input logic [SAMPLE_W-1:0] level, input logic chg);
		while (ticks_left > 1)
			send_word(SAMPLE_W'($urandom), 1'($urandom));
		send_word(level, chg);
		ticks_left = TICKS_PER_UPDATE;
		updates_sent++;
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (levels_owed != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Random bits above the register width must be dropped by the unit.
	function automatic logic [CFG_W-1:0] with_noise(input int unsigned value, input int width);
		return CFG_W'(($urandom << width) | value);
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] level;
		int                  directed;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_BRIGHTNESS;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		ticks_left = TICKS_PER_UPDATE + 1;
		burst_left = 1;
		gaps_on = 1'b1;
		updates_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: a full battery shows green, three empty samples turn it red.
		send_update(SAMPLE_FULL, 1'b0);
		send_update('0, 1'b0);
		send_update('0, 1'b0);
		send_update('0, 1'b0);
		// Charging shows cyan and leaves the ring alone.
		send_update(12'd2048, 1'b1);
		send_update(SAMPLE_FULL, 1'b0);

		// Override: white even while charging, then black, then the on-time floor, then indicator off.
		wait_idle();
		write_reg(REG_OVERRIDE_EN, with_noise(1, 1));
		write_reg(REG_OVERRIDE_CLR, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		send_update('0, 1'b1);
		wait_idle();
		write_reg(REG_OVERRIDE_CLR, 16'h0000);
		cfg_wr_en <= 1'b0;
		send_update('0, 1'b0);
		wait_idle();
		write_reg(REG_OVERRIDE_CLR, 16'h0821);
		cfg_wr_en <= 1'b0;
		send_update(SAMPLE_FULL, 1'b0);
		wait_idle();
		write_reg(REG_INDICATOR_ON, with_noise(0, 1));
		cfg_wr_en <= 1'b0;
		send_update(SAMPLE_FULL, 1'b0);

		// Back to the battery blend across the brightness extremes and the 0.05 clamp.
		wait_idle();
		write_reg(REG_INDICATOR_ON, 16'd1);
		write_reg(REG_OVERRIDE_EN, 16'd0);
		cfg_wr_en <= 1'b0;
		foreach (dim_steps[i]) begin
			wait_idle();
			write_reg(REG_BRIGHTNESS, with_noise(dim_steps[i], BRIGHT_W));
			cfg_wr_en <= 1'b0;
			send_update(SAMPLE_W'(1000 * i), 1'b0);
		end
		directed = updates_sent;

		while (updates_sent < directed + RANDOM_UPDATES) begin
			wait_idle();
			if ($urandom_range(0, 1))
				write_reg(REG_BRIGHTNESS, with_noise(($urandom_range(0, 3) == 0) ?
					dim_steps[$urandom_range(0, 4)] : $urandom_range(0, 255), BRIGHT_W));
			if ($urandom_range(0, 1))
				write_reg(REG_OVERRIDE_EN, with_noise($urandom_range(0, 3) == 0, 1));
			if ($urandom_range(0, 1))
				write_reg(REG_OVERRIDE_CLR, CFG_W'($urandom));
			if ($urandom_range(0, 1))
				write_reg(REG_INDICATOR_ON, with_noise($urandom_range(0, 3) != 0, 1));
			cfg_wr_en <= 1'b0;
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 7) == 0)
					level = $urandom_range(0, 1) ? SAMPLE_FULL : '0;
				else
					level = SAMPLE_W'($urandom);
				send_update(level, $urandom_range(0, 4) == 0);
			end
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("[battery_indicator_led_pwm_unit] OK");
		else
			$display("[battery_indicator_led_pwm_unit] ERROR");
		$finish;
	end

endmodule
